@@ design/u16u8_pkg.sv @@
// shared types, constants and utf-8 byte functions for the utf-16 to utf-8 transcoder
// no dependencies
package u16u8_pkg;

    localparam int CpW        = 21;
    localparam int QueueDepth = 4;
    localparam int QueuePtrW  = $clog2(QueueDepth);
    localparam int QueueCntW  = $clog2(QueueDepth + 1);

    localparam logic [15:0] HighFirst = 16'hd800;
    localparam logic [15:0] HighLast  = 16'hdbff;
    localparam logic [15:0] LowFirst  = 16'hdc00;
    localparam logic [15:0] LowLast   = 16'hdfff;

    localparam logic [CpW-1:0] SuppBase    = 21'h010000;
    localparam logic [CpW-1:0] Replacement = 21'h00fffd;
    localparam logic [5:0]     SurrPrefix  = 6'b110110;

    // one queued job: up to two code points, plus end-of-stream
    typedef struct packed {
        logic           cp0_v;
        logic [CpW-1:0] cp0;
        logic           cp1_v;
        logic [CpW-1:0] cp1;
        logic           last;
    } t_job;

    // number of utf-8 bytes minus one
    function automatic logic [1:0] utf8_len_m1(input logic [CpW-1:0] cp);
        logic [1:0] n;
        if (cp <= 21'h00007f) begin
            n = 2'd0;
        end else if (cp <= 21'h0007ff) begin
            n = 2'd1;
        end else if (cp <= 21'h00ffff) begin
            n = 2'd2;
        end else begin
            n = 2'd3;
        end
        return n;
    endfunction

    function automatic logic [7:0] utf8_byte(input logic [CpW-1:0] cp, input logic [1:0] idx);
        logic [7:0] b;
        unique case (utf8_len_m1(cp))
            2'd0: begin
                b = cp[7:0];
            end
            2'd1: begin
                b = (idx == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
            end
            2'd2: begin
                unique case (idx)
                    2'd0:    b = {4'b1110, cp[15:12]};
                    2'd1:    b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
            default: begin
                unique case (idx)
                    2'd0:    b = {5'b11110, cp[20:18]};
                    2'd1:    b = {2'b10, cp[17:12]};
                    2'd2:    b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
        endcase
        return b;
    endfunction

endpackage

@@ design/u16u8_front.sv @@
// front end: pairs bytes into code units, resolves surrogates, builds jobs
// depends on u16u8_pkg
module u16u8_front import u16u8_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_lsb_first,
    input  logic i_valid,
    input  logic [7:0] i_data,
    input  logic i_last,
    input  logic i_full,
    output logic o_ready,
    output logic o_push,
    output t_job o_job
);

    logic [7:0] r_held_byte;
    logic       r_byte_pending;
    logic [9:0] r_hs_bits;
    logic       r_sur_pending;

    logic [15:0]    w_unit;
    logic           w_is_high;
    logic           w_is_low;
    logic           w_accept;
    logic           w_c1v, w_c2v, w_c3v;
    logic [CpW-1:0] w_c2, w_c3;
    logic           w_sur_after;
    logic [9:0]     w_hs_after;

    assign o_ready  = !i_full;
    assign w_accept = i_valid && o_ready;

    assign w_unit    = i_lsb_first ? {i_data, r_held_byte} : {r_held_byte, i_data};
    assign w_is_high = (w_unit >= HighFirst) && (w_unit <= HighLast);
    assign w_is_low  = (w_unit >= LowFirst) && (w_unit <= LowLast);

    // broken pair replacement, then the unit itself, then raw high surrogate at end
    assign w_c1v = r_byte_pending && r_sur_pending && !w_is_low;
    assign w_c2v = r_byte_pending && !w_is_high;

    always_comb begin
        if (r_sur_pending && w_is_low) begin
            w_c2 = SuppBase + {1'b0, r_hs_bits, w_unit[9:0]};
        end else if (w_is_low) begin
            w_c2 = Replacement;
        end else begin
            w_c2 = {5'd0, w_unit};
        end
    end

    assign w_sur_after = r_byte_pending ? w_is_high : r_sur_pending;
    assign w_hs_after  = (r_byte_pending && w_is_high) ? w_unit[9:0] : r_hs_bits;
    assign w_c3v       = i_last && w_sur_after;
    assign w_c3        = {5'd0, SurrPrefix, w_hs_after};

    always_comb begin
        o_job.last = i_last;
        if (w_c1v) begin
            o_job.cp0_v = 1'b1;
            o_job.cp0   = Replacement;
            o_job.cp1_v = w_c2v || w_c3v;
            o_job.cp1   = w_c2v ? w_c2 : w_c3;
        end else begin
            o_job.cp0_v = w_c2v || w_c3v;
            o_job.cp0   = w_c2v ? w_c2 : w_c3;
            o_job.cp1_v = w_c2v && w_c3v;
            o_job.cp1   = w_c3;
        end
    end

    assign o_push = w_accept && (w_c1v || w_c2v || w_c3v || i_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_byte    <= '0;
            r_byte_pending <= 1'b0;
            r_hs_bits      <= '0;
            r_sur_pending  <= 1'b0;
        end else if (w_accept) begin
            if (i_last) begin
                r_held_byte    <= '0;
                r_byte_pending <= 1'b0;
                r_hs_bits      <= '0;
                r_sur_pending  <= 1'b0;
            end else if (r_byte_pending) begin
                r_byte_pending <= 1'b0;
                r_sur_pending  <= w_is_high;
                r_hs_bits      <= w_hs_after;
            end else begin
                r_held_byte    <= i_data;
                r_byte_pending <= 1'b1;
            end
        end
    end

endmodule

@@ design/u16u8_queue.sv @@
// short job queue between front end and byte emitter
// depends on u16u8_pkg
module u16u8_queue import u16u8_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_job,
    output logic o_full,
    output logic o_empty
);

    t_job                 r_mem [QueueDepth];
    logic [QueuePtrW-1:0] r_wr_ptr;
    logic [QueuePtrW-1:0] r_rd_ptr;
    logic [QueueCntW-1:0] r_count;

    logic w_push, w_pop;

    assign o_full  = (r_count == QueueCntW'(QueueDepth));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ design/u16u8_back.sv @@
// back end: walks a job's code points and sends one utf-8 byte per transfer
// depends on u16u8_pkg
module u16u8_back import u16u8_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_job       i_job,
    input  logic       i_empty,
    output logic       o_pop,
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,
    output logic       o_m_tlast,
    output logic [1:0] o_m_tuser
);

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } t_state;

    t_state     r_state;
    t_job       r_job;
    logic       r_sel;
    logic [1:0] r_idx;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_bvalid;
    logic       r_out_run_last;
    logic       r_out_done;

    logic [CpW-1:0] w_cp;
    logic           w_empty_mark;
    logic           w_cp_end;
    logic           w_run_end;
    logic           w_advance;
    logic           w_emit;
    logic           w_load;

    assign w_cp         = r_sel ? r_job.cp1 : r_job.cp0;
    assign w_empty_mark = !r_job.cp0_v;
    assign w_cp_end     = (r_idx == utf8_len_m1(w_cp));
    assign w_run_end    = w_empty_mark || (w_cp_end && (r_sel || !r_job.cp1_v));

    assign w_advance = !r_out_valid || i_m_tready;
    assign w_emit    = (r_state == ST_EMIT) && w_advance;
    assign w_load    = ((r_state == ST_IDLE) || (w_emit && w_run_end)) && !i_empty;
    assign o_pop     = w_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sel       <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_advance) begin
                r_out_valid <= w_emit;
            end
            if (w_emit) begin
                r_out_byte     <= w_empty_mark ? 8'd0 : utf8_byte(w_cp, r_idx);
                r_out_bvalid   <= !w_empty_mark;
                r_out_run_last <= w_run_end;
                r_out_done     <= w_run_end && r_job.last;
            end
            if (w_load) begin
                r_state <= ST_EMIT;
                r_job   <= i_job;
                r_sel   <= 1'b0;
                r_idx   <= '0;
            end else if (w_emit) begin
                if (w_run_end) begin
                    r_state <= ST_IDLE;
                end else if (w_cp_end) begin
                    r_sel <= 1'b1;
                    r_idx <= '0;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_byte;
    assign o_m_tlast  = r_out_run_last;
    assign o_m_tuser  = {r_out_done, r_out_bvalid};

endmodule

@@ design/utf16_to_utf8_transcoder.sv @@
// top level of the utf-16 to utf-8 transcoder: byte order register, front end, job queue,
// byte emitter and checks
// depends on u16u8_pkg, u16u8_front, u16u8_queue, u16u8_back
//
// Takes a utf-16 byte stream one byte per input transfer and sends utf-8 one byte per
// output transfer. Two bytes form a code unit, low byte first when the byte order
// register is 1 (its reset value); the register is sampled when the second byte of a unit
// arrives, so write it between streams. A high and low surrogate pair becomes one
// supplementary code point; a lone low surrogate, or a high surrogate not followed by a
// low one, becomes U+FFFD, and the unit after a broken pair is handled normally. When the
// stream ends with a high surrogate waiting, it goes out raw as three bytes; an odd
// trailing byte is dropped. tlast marks the last output byte caused by one input byte;
// tuser bit 1 marks the final output of the stream, and an input marked last that yields
// no byte gives one empty transfer with tuser bit 0 (byte valid) low and tdata zero. The
// front end accepts one input byte per cycle while its four-entry job queue has room;
// the emitter sends one output byte per cycle while the receiver is ready, and one input
// byte causes zero to six utf-8 bytes. The path from the second byte of a unit to its
// first output byte runs through the job queue, the emitter's job register and its output
// register. The front end's pairing and surrogate state returns to reset values after
// the stream's last byte.
module utf16_to_utf8_transcoder import u16u8_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_wr_data,     // lsb_first
    // utf-16 byte input
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,         // [7:0] data_byte
    input  logic       i_s_tlast,         // stream_last
    // utf-8 byte output
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,         // [7:0] utf8_byte
    output logic       o_m_tlast,         // run_last
    output logic [1:0] o_m_tuser          // [0] byte_valid, [1] stream_done
);

    logic r_lsb_first;

    t_job w_front_job;
    t_job w_queue_job;
    logic w_push;
    logic w_pop;
    logic w_full;
    logic w_empty;

    // byte order register; the user must write it only between streams, the block does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lsb_first <= 1'b1;
        end else if (i_cfg_wr_en) begin
            r_lsb_first <= i_cfg_wr_data;
        end
    end

    // pairs bytes and turns each input byte into at most one job
    u16u8_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_lsb_first (r_lsb_first),
        .i_valid     (i_s_tvalid),
        .i_data      (i_s_tdata),
        .i_last      (i_s_tlast),
        .i_full      (w_full),
        .o_ready     (o_s_tready),
        .o_push      (w_push),
        .o_job       (w_front_job)
    );

    // decouples input acceptance from output stalls
    u16u8_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_front_job),
        .i_pop   (w_pop),
        .o_job   (w_queue_job),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    // one utf-8 byte per output transfer, registered output
    u16u8_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job      (w_queue_job),
        .i_empty    (w_empty),
        .o_pop      (w_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

`ifndef NO_ASSERTIONS
    // a job is never offered to a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_full))
        else $error("job pushed into full queue");

    // the queue is never popped while empty
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_pop && w_empty))
        else $error("job popped from empty queue");

    // end of stream always closes a run
    a_done_closes_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[1]) |-> o_m_tlast)
        else $error("stream end without run end");

    // an empty marker only appears as the stream's final transfer with zero data
    a_empty_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser[0]) |-> (o_m_tlast && o_m_tuser[1] && (o_m_tdata == 8'd0)))
        else $error("empty marker outside stream end");
`endif

endmodule

@@ sim/tb_utf16_to_utf8_transcoder.sv @@
// self-checking testbench for the utf-16 to utf-8 transcoder: directed and random streams
// in both byte orders, a byte predictor and an in-order output scoreboard
// depends on u16u8_pkg and utf16_to_utf8_transcoder
module tb_utf16_to_utf8_transcoder import u16u8_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD    = 20;
    localparam int RESET_CYCLES  = 7;
    localparam int SETTLE_CYCLES = 12;      // margin on top of the unit latency
    localparam int CYCLE_LIMIT   = 200000;
    localparam int PHASE_BYTES   = 45;      // at least this many random input bytes per idle mode and byte order
    localparam bit MSB_FIRST     = 1'b0;
    localparam bit LSB_FIRST     = 1'b1;

    // one expected output transfer
    typedef struct {
        logic [7:0] data;
        logic       valid;
        logic       run_last;
        logic       done;
    } t_utf8_transfer;

    // predicts the utf-8 transfers of each accepted input byte and checks them in order
    class utf8_scoreboard;
        bit             lsb_first    = LSB_FIRST;
        logic [7:0]     held_byte    = '0;
        bit             byte_pending = 1'b0;
        logic [9:0]     high_bits    = '0;
        bit             surr_pending = 1'b0;
        logic [7:0]     step_bytes[$];
        t_utf8_transfer expected_q[$];
        int             errors  = 0;
        int             checked = 0;

        function int pending();
            return expected_q.size();
        endfunction

        function void add_byte(logic [7:0] b);
            step_bytes = {step_bytes, b};
        endfunction

        // utf-8 bytes of one code point
        function void put_point(logic [20:0] cp);
            if (cp <= 21'h7f) begin
                add_byte(cp[7:0]);
            end else if (cp <= 21'h7ff) begin
                add_byte(8'hc0 | {3'b0, cp[10:6]});
                add_byte(8'h80 | {2'b0, cp[5:0]});
            end else if (cp <= 21'hffff) begin
                add_byte(8'he0 | {4'b0, cp[15:12]});
                add_byte(8'h80 | {2'b0, cp[11:6]});
                add_byte(8'h80 | {2'b0, cp[5:0]});
            end else begin
                add_byte(8'hf0 | {5'b0, cp[20:18]});
                add_byte(8'h80 | {2'b0, cp[17:12]});
                add_byte(8'h80 | {2'b0, cp[11:6]});
                add_byte(8'h80 | {2'b0, cp[5:0]});
            end
        endfunction

        function void take_unit(logic [15:0] unit);
            bit is_high;
            bit is_low;
            is_high = unit >= HighFirst && unit <= HighLast;
            is_low  = unit >= LowFirst && unit <= LowLast;
            if (surr_pending) begin
                surr_pending = 1'b0;
                if (is_low) begin
                    put_point(SuppBase + {1'b0, high_bits, unit[9:0]});
                    return;
                end
                // broken pair, the current unit is still handled below
                put_point(Replacement);
            end
            if (is_high) begin
                surr_pending = 1'b1;
                high_bits    = unit[9:0];
            end else if (is_low) begin
                put_point(Replacement);
            end else begin
                put_point({5'b0, unit});
            end
        endfunction

        // called once per accepted input transfer
        function void note_byte(logic [7:0] b, logic last);
            t_utf8_transfer beat;
            step_bytes.delete();
            if (byte_pending) begin
                byte_pending = 1'b0;
                take_unit(lsb_first ? {b, held_byte} : {held_byte, b});
            end else begin
                held_byte    = b;
                byte_pending = 1'b1;
            end
            if (last) begin
                // waiting high surrogate leaves raw, odd byte is dropped
                if (surr_pending)
                    put_point({5'b0, HighFirst} + {11'b0, high_bits});
                held_byte    = '0;
                byte_pending = 1'b0;
                high_bits    = '0;
                surr_pending = 1'b0;
                if (step_bytes.size() == 0) begin
                    beat = '{data: 8'h00, valid: 1'b0, run_last: 1'b1, done: 1'b1};
                    expected_q = {expected_q, beat};
                    return;
                end
            end
            foreach (step_bytes[k]) begin
                beat.data     = step_bytes[k];
                beat.valid    = 1'b1;
                beat.run_last = (k == step_bytes.size() - 1);
                beat.done     = beat.run_last && last;
                expected_q = {expected_q, beat};
            end
        endfunction

        task report_mismatch(input string msg);
            errors++;
            $display("mismatch: %s", msg);
        endtask

        task check(input logic [7:0] data, input logic tlast, input logic [1:0] user);
            t_utf8_transfer want;
            checked++;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("unexpected transfer data %02h last %0b user %02b",
                                          data, tlast, user));
                return;
            end
            want = expected_q.pop_front();
            if (data !== want.data || tlast !== want.run_last ||
                user[0] !== want.valid || user[1] !== want.done)
                report_mismatch($sformatf(
                    "transfer %0d: got data %02h last %0b valid %0b done %0b, want %02h %0b %0b %0b",
                    checked, data, tlast, user[0], user[1],
                    want.data, want.run_last, want.valid, want.done));
        endtask
    endclass

    // clock, reset and block inputs, all known from time zero
    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_cfg_wr_en   = 1'b0;
    logic       i_cfg_wr_data = 1'b0;
    logic       i_s_tvalid    = 1'b0;
    logic [7:0] i_s_tdata     = '0;
    logic       i_s_tlast     = 1'b0;
    logic       i_m_tready    = 1'b0;
    logic       o_s_tready;
    logic       o_m_tvalid;
    logic [7:0] o_m_tdata;
    logic       o_m_tlast;
    logic [1:0] o_m_tuser;

    utf8_scoreboard sb = new();
    int             src_idle_pct = 0;   // chance in percent that the sender holds back a cycle
    int             snk_idle_pct = 0;   // chance in percent that the receiver stalls a cycle
    int             cycles       = 0;
    int             bytes_sent   = 0;
    int             streams_sent = 0;
    logic [15:0]    stream_units[$];    // code units of the stream being built

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    utf16_to_utf8_transcoder DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_s_tvalid   (i_s_tvalid),
        .o_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),      // [7:0] data_byte
        .i_s_tlast    (i_s_tlast),      // stream_last
        .o_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .o_m_tdata    (o_m_tdata),      // [7:0] utf8_byte
        .o_m_tlast    (o_m_tlast),      // run_last
        .o_m_tuser    (o_m_tuser)       // [0] byte_valid, [1] stream_done
    );

    // run limit, far above the slowest correct run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d transfers still expected",
                     cycles, sb.pending());
            $display("[utf16_to_utf8_transcoder] ERROR");
            $finish;
        end
    end

    // receiver: values read right after the edge are the ones the edge sampled
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check(o_m_tdata, o_m_tlast, o_m_tuser);
        i_m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // one input transfer, with random gaps in front of it
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        sb.note_byte(b, last);
        bytes_sent++;
    endtask

    // register write only once the block has gone quiet
    task automatic set_byte_order(input bit order);
        i_s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        // a byte with no output may still be in flight
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= order;
        @(posedge i_clk);
        i_cfg_wr_en  <= 1'b0;
        sb.lsb_first  = order;
    endtask

    // serialize the collected units in the current byte order, tlast on the final byte
    task automatic send_stream(input bit add_tail, input logic [7:0] tail);
        logic [7:0] seq[$];
        foreach (stream_units[k]) begin
            if (sb.lsb_first) begin
                seq = {seq, stream_units[k][7:0]};
                seq = {seq, stream_units[k][15:8]};
            end else begin
                seq = {seq, stream_units[k][15:8]};
                seq = {seq, stream_units[k][7:0]};
            end
        end
        if (add_tail)
            seq = {seq, tail};
        foreach (seq[k])
            send_byte(seq[k], k == seq.size() - 1);
        stream_units.delete();
        streams_sent++;
    endtask

    // one character, mostly well formed, sometimes a stray surrogate
    task automatic add_random_char();
        int pick;
        pick = $urandom_range(99);
        if (pick < 30) begin
            stream_units = {stream_units, 16'($urandom_range(16'h007f))};
        end else if (pick < 45) begin
            stream_units = {stream_units, 16'($urandom_range(16'h07ff, 16'h0080))};
        end else if (pick < 65) begin
            if ($urandom_range(1))
                stream_units = {stream_units, 16'($urandom_range(16'hd7ff, 16'h0800))};
            else
                stream_units = {stream_units, 16'($urandom_range(16'hffff, 16'he000))};
        end else if (pick < 83) begin
            // surrogate pair
            stream_units = {stream_units, HighFirst | 16'($urandom_range(10'h3ff))};
            stream_units = {stream_units, LowFirst | 16'($urandom_range(10'h3ff))};
        end else if (pick < 89) begin
            stream_units = {stream_units, LowFirst | 16'($urandom_range(10'h3ff))};
        end else if (pick < 95) begin
            stream_units = {stream_units, HighFirst | 16'($urandom_range(10'h3ff))};
        end else begin
            stream_units = {stream_units, 16'($urandom_range(16'hffff))};
        end
    endtask

    task automatic send_random_stream();
        int n_units;
        if ($urandom_range(99) < 10) begin
            // noise: raw random bytes, odd lengths included
            n_units = $urandom_range(3);
            repeat (n_units)
                stream_units = {stream_units, 16'($urandom_range(16'hffff))};
            send_stream(n_units == 0 || $urandom_range(1), 8'($urandom_range(255)));
            return;
        end
        n_units = $urandom_range(8, 1);
        repeat (n_units)
            add_random_char();
        // sometimes leave a high surrogate waiting at the end
        if ($urandom_range(99) < 8)
            stream_units = {stream_units, HighFirst | 16'($urandom_range(10'h3ff))};
        send_stream($urandom_range(99) < 12, 8'($urandom_range(255)));
    endtask

    initial begin
        int phase_start;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part, sender idles 18 percent and receiver 45
        src_idle_pct = 18;
        snk_idle_pct = 45;
        // low byte first from reset: range ends of each utf-8 length and the smallest pair
        stream_units = {16'h0000, 16'h007f, 16'h07ff, 16'hffff, 16'hd800, 16'hdc00};
        send_stream(1'b0, 8'h00);
        // lone low, high followed by high, and the top code point
        stream_units = {16'hdfff, 16'hdbff, 16'hd800, 16'hdbff, 16'hdfff};
        send_stream(1'b0, 8'h00);
        // broken pair plus high surrogate left at the end: six bytes from one input
        stream_units = {16'hdbff, 16'hd800};
        send_stream(1'b0, 8'h00);
        // single odd byte: dropped, only the empty end marker comes out
        send_byte(8'hff, 1'b1);
        streams_sent++;
        set_byte_order(MSB_FIRST);
        // high byte first: two-byte char, high surrogate broken by ascii, odd tail byte
        stream_units = {16'h0080, 16'hd900, 16'h0041};
        send_stream(1'b1, 8'haa);
        // byte order flipped between the two bytes of one unit
        send_byte(8'h12, 1'b0);
        set_byte_order(LSB_FIRST);
        send_byte(8'h34, 1'b1);
        streams_sent++;

        // random part: three idle modes, each in both byte orders
        for (int mode = 0; mode < 3; mode++) begin
            for (int o = 0; o < 2; o++) begin
                src_idle_pct = (mode == 0) ? 18 : (mode == 1) ? 45 : 0;
                snk_idle_pct = (mode == 0) ? 45 : (mode == 1) ? 18 : 0;
                set_byte_order(o == 0 ? MSB_FIRST : LSB_FIRST);
                phase_start = bytes_sent;
                while (bytes_sent - phase_start < PHASE_BYTES)
                    send_random_stream();
            end
        end

        // drain and give stray outputs a chance to show up
        i_s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES * 2) @(posedge i_clk);

        $display("ran %0d utf-16 bytes in %0d streams, both byte orders, three idle modes",
                 bytes_sent, streams_sent);
        $display("checked %0d utf-8 transfers, %0d mismatches", sb.checked, sb.errors);
        if (sb.errors == 0) begin
            $display("[utf16_to_utf8_transcoder] OK");
        end else begin
            $display("[utf16_to_utf8_transcoder] ERROR");
        end
        $finish;
    end

endmodule

@@ utf16_to_utf8_transcoder.f @@
design/u16u8_pkg.sv
design/u16u8_front.sv
design/u16u8_queue.sv
design/u16u8_back.sv
design/utf16_to_utf8_transcoder.sv
sim/tb_utf16_to_utf8_transcoder.sv
